### hdl/sru_pkg.sv
// shared constants, codes and types of the station registry unit
package sru_pkg;

  // default number of table entries
  localparam int unsigned TableDepthDef = 16;

  // field widths
  localparam int unsigned OpW     = 3;
  localparam int unsigned KeyW    = 16;
  localparam int unsigned LinkW   = 16;
  localparam int unsigned CtrW    = 4;
  localparam int unsigned StatW   = 2;
  localparam int unsigned OutCntW = 5;
  localparam int unsigned LimitW  = 4;

  // configuration port
  localparam int unsigned PAddrW = 2;
  localparam int unsigned PDataW = 32;
  localparam logic [PAddrW-1:0] AddrMissLimit = '0;
  localparam logic [LimitW-1:0] MissLimitRst  = 4'd3;

  // miss counter saturates here
  localparam logic [CtrW-1:0] CtrTop = 4'hF;

  // operation codes
  typedef enum logic [OpW-1:0] {
    OP_INSERT   = 3'd0,
    OP_DELETE   = 3'd1,
    OP_CHANGE   = 3'd2,
    OP_LOOKUP   = 3'd3,
    OP_SWEEP    = 3'd4,
    OP_PRESENCE = 3'd5
  } op_e;

  // result status codes
  typedef enum logic [StatW-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } stat_e;

  // one table entry as stored in memory
  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [LinkW-1:0] link;
    logic [CtrW-1:0]  ctr;
  } entry_t;

  // controller to datapath commands
  typedef struct packed {
    logic start;
    logic ins;
    logic scan_en;
    logic find_end;
    logic cmpt_en;
    logic cmpt_end;
    logic res_load;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    op_e  op;
    logic walk_done;
    logic hit;
  } dp_sts_t;

endpackage

### hdl/sru_in_if.sv
// request channel of the station registry unit
interface sru_in_if;
  logic                        valid;
  logic                        ready;
  logic [sru_pkg::OpW-1:0]     operation;
  logic [sru_pkg::KeyW-1:0]    station_id;
  logic [sru_pkg::LinkW-1:0]   link_id;

  modport source (output valid, output operation, output station_id, output link_id,
                  input ready);
  modport sink   (input valid, input operation, input station_id, input link_id,
                  output ready);
endinterface

### hdl/sru_out_if.sv
// result channel of the station registry unit
interface sru_out_if;
  logic                         valid;
  logic                         ready;
  logic [sru_pkg::StatW-1:0]    status;
  logic [sru_pkg::LinkW-1:0]    link_id_out;
  logic [sru_pkg::OutCntW-1:0]  removed_count;
  logic [sru_pkg::OutCntW-1:0]  entries_used;

  modport source (output valid, output status, output link_id_out, output removed_count,
                  output entries_used, input ready);
  modport sink   (input valid, input status, input link_id_out, input removed_count,
                  input entries_used, output ready);
endinterface

### hdl/sru_ram.sv
// generic single write port ram with registered read
module sru_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/sru_datapath.sv
// table memory, walk pointers, match tracking and result register
module sru_datapath #(
  parameter int unsigned TableDepth = sru_pkg::TableDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [sru_pkg::OpW-1:0]       operation_i,
  input  logic [sru_pkg::KeyW-1:0]      station_id_i,
  input  logic [sru_pkg::LinkW-1:0]     link_id_i,
  input  logic [sru_pkg::LimitW-1:0]    miss_limit_i,
  input  sru_pkg::dp_cmd_t              cmd_i,
  output sru_pkg::dp_sts_t              sts_o,
  output logic [sru_pkg::StatW-1:0]     status_o,
  output logic [sru_pkg::LinkW-1:0]     link_id_out_o,
  output logic [sru_pkg::OutCntW-1:0]   removed_count_o,
  output logic [sru_pkg::OutCntW-1:0]   entries_used_o
);
  import sru_pkg::*;

  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(TableDepth);

  // control state
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] rd_q, rd_d;
  logic [CntW-1:0] wr_q, wr_d;
  logic [CntW-1:0] removed_q, removed_d;
  logic            pend_vld_q, pend_vld_d;
  logic            hit_q, hit_d;
  stat_e           stat_q, stat_d;

  // payload state
  op_e              op_q;
  logic [KeyW-1:0]  key_q;
  logic [LinkW-1:0] link_q;
  logic [IdxW-1:0]  pend_idx_q;
  logic [IdxW-1:0]  pos_q, pos_d;
  entry_t           hit_ent_q, hit_ent_d;

  // output word
  logic [StatW-1:0]   res_stat_q;
  logic [LinkW-1:0]   res_link_q;
  logic [OutCntW-1:0] res_removed_q;
  logic [OutCntW-1:0] res_used_q;

  // memory port signals
  logic             ram_we;
  logic [IdxW-1:0]  ram_waddr;
  entry_t           ram_wdata;
  logic [IdxW-1:0]  ram_raddr;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t           rd_ent;

  logic walk_en;
  logic issue;
  logic drop;
  logic [CtrW-1:0] ctr_inc;

  sru_ram #(
    .Width($bits(entry_t)),
    .Depth(TableDepth)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_ent    = entry_t'(ram_rdata);
  assign walk_en   = cmd_i.scan_en | cmd_i.cmpt_en;
  assign issue     = walk_en && (rd_q < count_q);
  assign ram_raddr = rd_q[IdxW-1:0];
  assign ctr_inc   = (rd_ent.ctr < CtrTop) ? rd_ent.ctr + CtrW'(1) : CtrTop;
  assign drop      = (op_q == OP_SWEEP) ? (rd_ent.ctr >= miss_limit_i)
                                        : (pend_idx_q == pos_q);

  // walk, match, compaction and memory write
  always_comb begin
    count_d    = count_q;
    rd_d       = rd_q;
    wr_d       = wr_q;
    removed_d  = removed_q;
    pend_vld_d = issue;
    hit_d      = hit_q;
    stat_d     = stat_q;
    pos_d      = pos_q;
    hit_ent_d  = hit_ent_q;
    ram_we     = 1'b0;
    ram_waddr  = count_q[IdxW-1:0];
    ram_wdata  = '{key: key_q, link: link_q, ctr: '0};

    if (issue) begin
      rd_d = rd_q + CntW'(1);
    end

    // scan for the last matching key
    if (cmd_i.scan_en && pend_vld_q && (rd_ent.key == key_q)) begin
      hit_d     = 1'b1;
      pos_d     = pend_idx_q;
      hit_ent_d = rd_ent;
    end

    // compaction pass: drop or move down each entry, raising the miss counter on a sweep
    if (cmd_i.cmpt_en && pend_vld_q) begin
      if (drop) begin
        removed_d = removed_q + CntW'(1);
      end else begin
        ram_we    = 1'b1;
        ram_waddr = wr_q[IdxW-1:0];
        ram_wdata = '{key:  rd_ent.key,
                      link: rd_ent.link,
                      ctr:  (op_q == OP_SWEEP) ? ctr_inc : rd_ent.ctr};
        wr_d      = wr_q + CntW'(1);
      end
    end

    if (cmd_i.cmpt_end) begin
      count_d = wr_q;
    end

    // append on insert
    if (cmd_i.ins) begin
      if (count_q == CntFull) begin
        stat_d = ST_FULL;
      end else begin
        ram_we    = 1'b1;
        ram_waddr = count_q[IdxW-1:0];
        ram_wdata = '{key: key_q, link: link_q, ctr: '0};
        count_d   = count_q + CntW'(1);
      end
    end

    // act on the match once the scan is over
    if (cmd_i.find_end) begin
      if (!hit_q) begin
        stat_d = ST_NOT_FOUND;
      end else if (op_q == OP_CHANGE) begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = '{key: hit_ent_q.key, link: link_q, ctr: hit_ent_q.ctr};
      end else if (op_q == OP_PRESENCE) begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = '{key: hit_ent_q.key, link: hit_ent_q.link, ctr: '0};
      end else if (op_q == OP_DELETE) begin
        rd_d       = '0;
        wr_d       = '0;
        removed_d  = '0;
        pend_vld_d = 1'b0;
      end
    end

    // new request
    if (cmd_i.start) begin
      rd_d       = '0;
      wr_d       = '0;
      removed_d  = '0;
      pend_vld_d = 1'b0;
      hit_d      = 1'b0;
      stat_d     = ST_OK;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      rd_q       <= '0;
      wr_q       <= '0;
      removed_q  <= '0;
      pend_vld_q <= 1'b0;
      hit_q      <= 1'b0;
      stat_q     <= ST_OK;
    end else begin
      count_q    <= count_d;
      rd_q       <= rd_d;
      wr_q       <= wr_d;
      removed_q  <= removed_d;
      pend_vld_q <= pend_vld_d;
      hit_q      <= hit_d;
      stat_q     <= stat_d;
    end
  end

  // request capture, match data and result word
  always_ff @(posedge clk_i) begin
    pend_idx_q <= rd_q[IdxW-1:0];
    pos_q      <= pos_d;
    hit_ent_q  <= hit_ent_d;
    if (cmd_i.start) begin
      op_q   <= op_e'(operation_i);
      key_q  <= station_id_i;
      link_q <= link_id_i;
    end
    if (cmd_i.res_load) begin
      res_stat_q    <= stat_q;
      res_link_q    <= (op_q == OP_LOOKUP && hit_q) ? hit_ent_q.link : '0;
      res_removed_q <= OutCntW'(removed_q);
      res_used_q    <= OutCntW'(count_q);
    end
  end

  assign sts_o.op        = op_q;
  assign sts_o.walk_done = (rd_q == count_q) && !pend_vld_q;
  assign sts_o.hit       = hit_q;

  assign status_o        = res_stat_q;
  assign link_id_out_o   = res_link_q;
  assign removed_count_o = res_removed_q;
  assign entries_used_o  = res_used_q;

endmodule

### hdl/sru_ctrl.sv
// sequencer for one request at a time and the result handshake
module sru_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  sru_pkg::dp_sts_t  sts_i,
  output sru_pkg::dp_cmd_t  cmd_o
);
  import sru_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_SCAN   = 5'b00100,
    S_CMPT   = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;

  // next state and commands
  always_comb begin
    state_d   = state_q;
    out_vld_d = out_vld_q;
    cmd_o     = '0;

    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.op) inside
          OP_INSERT: begin
            cmd_o.ins = 1'b1;
            state_d   = S_DONE;
          end
          OP_DELETE, OP_CHANGE, OP_LOOKUP, OP_PRESENCE: begin
            state_d = S_SCAN;
          end
          OP_SWEEP: begin
            state_d = S_CMPT;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.walk_done) begin
          cmd_o.find_end = 1'b1;
          if (sts_i.hit && (sts_i.op == OP_DELETE)) begin
            state_d = S_CMPT;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_CMPT: begin
        cmd_o.cmpt_en = 1'b1;
        if (sts_i.walk_done) begin
          cmd_o.cmpt_end = 1'b1;
          state_d        = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          out_vld_d      = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;

endmodule

### hdl/station_registry_with_aging_unit.sv
// Station registry with aging: ordered table of station id to link id with miss counters.
//
// item_i carries one request word (operation, station_id, link_id); result_o returns one
// result word (status, link_id_out, removed_count, entries_used) for every request.
// Both channels move a word when valid and ready are high at a rising clock edge.
// miss_limit is written over the APB port at byte address 0; pready is always high.
//
// Insert and unused codes need no walk over the table; change, lookup, presence seen,
// aging sweep and delete without a match take one walk, and delete with a match takes
// two (scan, then compaction pass). The walk runs over the table memory, one entry
// read per cycle through its single registered read port. A new word is taken once
// the sequencer is back in idle after the previous result is loaded.
//
// The result sits in an output register; a stalled receiver holds it there while
// the next request is accepted and processed, which then waits to load its result.
// Reset empties the table and sets miss_limit to 3; entry contents are not cleared.
module station_registry_with_aging_unit #(
  parameter int unsigned TableDepth = sru_pkg::TableDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  sru_in_if.sink                       item_i,
  sru_out_if.source                    result_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sru_pkg::PAddrW-1:0]   paddr,
  input  logic [sru_pkg::PDataW-1:0]   pwdata,
  output logic [sru_pkg::PDataW-1:0]   prdata,
  output logic                         pready
);
  import sru_pkg::*;

  logic [LimitW-1:0] miss_limit_q;
  logic              cfg_wr;
  dp_cmd_t           cmd;
  dp_sts_t           sts;

  // configuration register
  assign cfg_wr = psel && penable && pwrite && (paddr == AddrMissLimit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miss_limit_q <= MissLimitRst;
    end else if (cfg_wr) begin
      miss_limit_q <= pwdata[LimitW-1:0];
    end
  end

  assign prdata = PDataW'(miss_limit_q);
  assign pready = 1'b1;

  // sequencer
  sru_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .out_valid_o(result_o.valid),
    .out_ready_i(result_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // table and result datapath
  sru_datapath #(
    .TableDepth(TableDepth)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .operation_i    (item_i.operation),
    .station_id_i   (item_i.station_id),
    .link_id_i      (item_i.link_id),
    .miss_limit_i   (miss_limit_q),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .status_o       (result_o.status),
    .link_id_out_o  (result_o.link_id_out),
    .removed_count_o(result_o.removed_count),
    .entries_used_o (result_o.entries_used)
  );

endmodule
